>>> sv/cel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cel_pkg
// shared types, codes and crc helper for the crc checked ring event log
// ----------------------------------------------------------------------------
package cel_pkg;

	localparam int SLOTS_DEF = 64;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] REC_LEN = 16'd20;
	localparam int IMG_BYTES = 32;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_RESCAN = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CRC,
		ST_WALK,
		ST_DONE
	} cel_state_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] crc;
		logic [31:0] dh;
		logic [63:0] dm;
		logic [63:0] dl;
		logic [31:0] tick;
		logic [7:0]  typ;
		logic [31:0] seq;
	} rec_t;

	typedef struct packed {
		logic [15:0] crc;
		logic [10:0] count;
		logic [9:0]  slot;
		logic [31:0] dh;
		logic [63:0] dm;
		logic [63:0] dl;
		logic [31:0] tick;
		logic [7:0]  typ;
		logic [31:0] seq;
		logic        ok;
	} res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> sv/cel_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cel_crc
// serial crc-16-ccitt engine, one byte of the 32-byte record image per cycle
// ----------------------------------------------------------------------------
module cel_crc (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [255:0] img,
	output logic         done,
	output logic [15:0]  crc
);

	logic [255:0] img_q;
	logic [15:0]  crc_q;
	logic [4:0]   cnt_q;
	logic         run_q;
	logic [15:0]  crc_next;

	assign crc_next = cel_pkg::crc_byte(crc_q, img_q[7:0]);
	assign done = run_q && (cnt_q == 5'(cel_pkg::IMG_BYTES - 1));
	assign crc = crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			img_q <= img;
			crc_q <= cel_pkg::CRC_INIT;
		end else if (run_q) begin
			img_q <= {8'h00, img_q[255:8]};
			crc_q <= crc_next;
		end
	end

endmodule

>>> sv/crc_checked_ring_event_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_ring_event_log
// ring of crc protected event records held in one synchronous memory
// ----------------------------------------------------------------------------
// channel   dir  tdata                                         tuser
// s_axis    in   type, tick, detail low/mid/high, index        command
// m_axis    out  ok, seq, type, tick, details, slot, count, crc -
//
// on append the crc engine folds one image byte per cycle
// read and rescan walk the ring with one memory read per slot
// after reset a clearing pass marks every slot empty
// a new command is taken while an earlier result waits on m_axis
// ----------------------------------------------------------------------------
module crc_checked_ring_event_log #(
	parameter int SLOTS = cel_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// event_type, tick_ms, detail_low, detail_middle, detail_high, record_index
	input  logic [215:0] s_tdata,
	// command
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// ok, seq_out, type_out, tick_out, detail_low_out, detail_middle_out,
	// detail_high_out, slot_out, count_out, crc_out
	output logic [271:0] m_tdata
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
	localparam logic [CW-1:0] FULL = CW'(SLOTS);

	cel_pkg::cel_state_t state_q, state_d;
	cel_pkg::rec_t mem [SLOTS];
	cel_pkg::rec_t rdata_s1, wdata;
	cel_pkg::res_t res_q, out_q;

	logic [1:0]    cmd_q;
	logic [7:0]    type_q;
	logic [31:0]   tick_q;
	logic [63:0]   dl_q, dm_q;
	logic [31:0]   dh_q;
	logic [9:0]    want_q;
	logic [31:0]   seq_q;
	logic [SW-1:0] wslot_q, addr_q, slot_s1, max_slot_q;
	logic [CW-1:0] count_q, issued_q, cnt_q;
	logic [31:0]   max_seq_q;
	logic          found_q, pend_s1, out_vld_q;

	logic          accept, out_free, hit, walk_end, issue, mem_we;
	logic          crc_start, crc_done;
	logic [15:0]   crc_val;
	logic [SW-1:0] waddr;
	logic [1:0]    cmd_in;
	logic [31:0]   seq_inc;

	function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s);
		return (s == LAST) ? '0 : s + SW'(1);
	endfunction

	function automatic logic [SW-1:0] dec_slot(input logic [SW-1:0] s);
		return (s == '0) ? LAST : s - SW'(1);
	endfunction

	assign cmd_in = s_tuser;
	assign seq_inc = seq_q + 32'd1;
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;
	assign crc_start = accept && (cmd_in == cel_pkg::CMD_APPEND);
	assign hit = (state_q == cel_pkg::ST_WALK) && (cmd_q == cel_pkg::CMD_READ) && pend_s1
		&& rdata_s1.valid && (want_q == 10'd0);
	assign walk_end = !pend_s1 && (issued_q == FULL);
	assign issue = (state_q == cel_pkg::ST_WALK) && (issued_q != FULL) && !hit;
	assign mem_we = (state_q == cel_pkg::ST_CLEAR) || ((state_q == cel_pkg::ST_CRC) && crc_done);
	assign waddr = (state_q == cel_pkg::ST_CLEAR) ? addr_q : wslot_q;

	always_comb begin
		wdata = '0;
		if (state_q != cel_pkg::ST_CLEAR) begin
			wdata.valid = 1'b1;
			wdata.crc = crc_val;
			wdata.dh = dh_q;
			wdata.dm = dm_q;
			wdata.dl = dl_q;
			wdata.tick = tick_q;
			wdata.typ = type_q;
			wdata.seq = seq_q;
		end
	end

	cel_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crc_start),
		.img    ({s_tdata[199:168], s_tdata[167:104], s_tdata[103:40], s_tdata[39:8],
			cel_pkg::REC_LEN, 8'h00, s_tdata[7:0], seq_inc}),
		.done   (crc_done),
		.crc    (crc_val)
	);

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			cel_pkg::ST_CLEAR: begin
				if (addr_q == LAST) begin
					state_d = cel_pkg::ST_IDLE;
				end
			end
			cel_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (cmd_in)
						cel_pkg::CMD_APPEND: state_d = cel_pkg::ST_CRC;
						cel_pkg::CMD_READ:
							state_d = (count_q == '0) ? cel_pkg::ST_DONE : cel_pkg::ST_WALK;
						cel_pkg::CMD_RESCAN: state_d = cel_pkg::ST_WALK;
						default: state_d = cel_pkg::ST_DONE;
					endcase
				end
			end
			cel_pkg::ST_CRC: begin
				if (crc_done) begin
					state_d = cel_pkg::ST_DONE;
				end
			end
			cel_pkg::ST_WALK: begin
				if (hit || walk_end) begin
					state_d = cel_pkg::ST_DONE;
				end
			end
			cel_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = cel_pkg::ST_IDLE;
				end
			end
			default: state_d = cel_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cel_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// record memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			seq_q <= '0;
			wslot_q <= '0;
			count_q <= '0;
			pend_s1 <= 1'b0;
			issued_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if ((state_q == cel_pkg::ST_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			pend_s1 <= issue;
			unique case (state_q)
				cel_pkg::ST_CLEAR: begin
					addr_q <= inc_slot(addr_q);
				end
				cel_pkg::ST_IDLE: begin
					issued_q <= '0;
					if (accept) begin
						if (cmd_in == cel_pkg::CMD_APPEND) begin
							seq_q <= seq_inc;
						end
						addr_q <= (cmd_in == cel_pkg::CMD_READ) ? dec_slot(wslot_q) : '0;
					end
				end
				cel_pkg::ST_CRC: begin
					if (crc_done) begin
						wslot_q <= inc_slot(wslot_q);
						if (count_q != FULL) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				cel_pkg::ST_WALK: begin
					if (issue) begin
						issued_q <= issued_q + CW'(1);
						addr_q <= (cmd_q == cel_pkg::CMD_READ) ? dec_slot(addr_q) : inc_slot(addr_q);
					end
					if (walk_end && (cmd_q == cel_pkg::CMD_RESCAN)) begin
						count_q <= cnt_q;
						seq_q <= found_q ? max_seq_q : 32'd0;
						wslot_q <= found_q ? inc_slot(max_slot_q) : '0;
					end
				end
				cel_pkg::ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// command fields, walk accumulators and result
	always_ff @(posedge clk) begin
		if ((state_q == cel_pkg::ST_DONE) && out_free) begin
			out_q <= res_q;
		end
		if (accept) begin
			cmd_q <= cmd_in;
			type_q <= s_tdata[7:0];
			tick_q <= s_tdata[39:8];
			dl_q <= s_tdata[103:40];
			dm_q <= s_tdata[167:104];
			dh_q <= s_tdata[199:168];
			want_q <= s_tdata[209:200];
			cnt_q <= '0;
			max_seq_q <= '0;
			max_slot_q <= '0;
			found_q <= 1'b0;
			res_q <= '{count: 11'(count_q), default: '0};
		end
		slot_s1 <= addr_q;
		if ((state_q == cel_pkg::ST_CRC) && crc_done) begin
			res_q.ok <= 1'b1;
			res_q.seq <= seq_q;
			res_q.slot <= 10'(wslot_q);
			res_q.crc <= crc_val;
			res_q.count <= (count_q != FULL) ? 11'(count_q + CW'(1)) : 11'(count_q);
		end
		if ((state_q == cel_pkg::ST_WALK) && pend_s1 && rdata_s1.valid) begin
			if (cmd_q == cel_pkg::CMD_READ) begin
				if (want_q == 10'd0) begin
					res_q.ok <= 1'b1;
					res_q.seq <= rdata_s1.seq;
					res_q.typ <= rdata_s1.typ;
					res_q.tick <= rdata_s1.tick;
					res_q.dl <= rdata_s1.dl;
					res_q.dm <= rdata_s1.dm;
					res_q.dh <= {8'h00, rdata_s1.dh[23:0]};
					res_q.slot <= 10'(slot_s1);
					res_q.crc <= rdata_s1.crc;
				end else begin
					want_q <= want_q - 10'd1;
				end
			end else begin
				cnt_q <= cnt_q + CW'(1);
				if (rdata_s1.seq >= max_seq_q) begin
					max_seq_q <= rdata_s1.seq;
					max_slot_q <= slot_s1;
					found_q <= 1'b1;
				end
			end
		end
		if ((state_q == cel_pkg::ST_WALK) && walk_end && (cmd_q == cel_pkg::CMD_RESCAN)) begin
			res_q.ok <= 1'b1;
			res_q.seq <= found_q ? max_seq_q : 32'd0;
			res_q.count <= 11'(cnt_q);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {2'b00, out_q};

endmodule

>>> sv/cel_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cel_chk
// port level checks for the crc checked ring event log
// ----------------------------------------------------------------------------
module cel_chk #(
	parameter int SLOTS = cel_pkg::SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [271:0] m_tdata
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while busy");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[253:243] <= 11'(SLOTS)))
		else $error("count above slot total");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[32:1] == 32'd0) && (m_tdata[242:233] == 10'd0)
			&& (m_tdata[269:254] == 16'd0))
		else $error("failed transfer carries record fields");

endmodule

bind crc_checked_ring_event_log cel_chk #(.SLOTS(SLOTS)) u_cel_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> test/tb_crc_checked_ring_event_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc_checked_ring_event_log
// self-checking bench for the crc checked event ring: a directed opening and
// random append, read, rescan and unused commands are streamed in with random
// gaps and output stalls, and each result is checked against a local model
// of the ring with its own crc-16-ccitt over the 32-byte record image
// ----------------------------------------------------------------------------
module tb_crc_checked_ring_event_log;

	localparam int RING = 64;
	localparam int WATCHDOG = 5000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  typ;
		logic [31:0] tick;
		logic [63:0] dl;
		logic [63:0] dm;
		logic [31:0] dh;
		logic [9:0]  idx;
	} event_cmd_t;

	typedef struct {
		logic        ok;
		logic [31:0] seq;
		logic [7:0]  typ;
		logic [31:0] tick;
		logic [63:0] dl;
		logic [63:0] dm;
		logic [31:0] dh;
		logic [9:0]  slot;
		logic [10:0] count;
		logic [15:0] crc;
	} log_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [215:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [271:0] m_tdata;

	crc_checked_ring_event_log dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// ring copy
	logic [31:0] ring_seq[RING];
	logic [7:0]  ring_typ[RING];
	logic [31:0] ring_tick[RING];
	logic [63:0] ring_dl[RING];
	logic [63:0] ring_dm[RING];
	logic [31:0] ring_dh[RING];
	logic [15:0] ring_crc[RING];
	logic        ring_used[RING];
	logic [31:0] last_seq;
	int          next_slot;
	int          live_count;

	event_cmd_t  pending_cmds[$];
	log_result_t expected_results[$];
	int          errors;
	int          quiet_cycles;
	logic        in_taken;
	int          gap_left;
	int          stall_left;
	logic        calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] crc_fold(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [15:0] image_crc(input logic [31:0] seq, input logic [7:0] typ,
			input logic [31:0] tick, input logic [63:0] dl, input logic [63:0] dm,
			input logic [31:0] dh);
		logic [255:0] img;
		logic [15:0]  c;
		img = {dh, dm, dl, tick, 16'd20, 8'd0, typ, seq};
		c = 16'hFFFF;
		for (int i = 0; i < 32; i++) begin
			c = crc_fold(c, img[8*i +: 8]);
		end
		return c;
	endfunction

	function automatic log_result_t log_step(input event_cmd_t it);
		log_result_t r;
		int s;
		int want;
		logic [31:0] top;
		logic found;
		r = '{default: '0};
		case (it.cmd)
			cel_pkg::CMD_APPEND: begin
				s = next_slot;
				last_seq = last_seq + 32'd1;
				ring_seq[s] = last_seq;
				ring_typ[s] = it.typ;
				ring_tick[s] = it.tick;
				ring_dl[s] = it.dl;
				ring_dm[s] = it.dm;
				ring_dh[s] = it.dh;
				ring_crc[s] = image_crc(last_seq, it.typ, it.tick, it.dl, it.dm, it.dh);
				ring_used[s] = 1'b1;
				if (live_count < RING) live_count++;
				next_slot = (s + 1) % RING;
				r.ok = 1'b1;
				r.seq = last_seq;
				r.slot = s[9:0];
				r.crc = ring_crc[s];
			end
			cel_pkg::CMD_READ: begin
				want = it.idx;
				if (live_count != 0) begin
					s = (next_slot + RING - 1) % RING;
					for (int i = 0; i < RING; i++) begin
						if (ring_used[s]) begin
							if (want == 0) begin
								r.ok = 1'b1;
								r.seq = ring_seq[s];
								r.typ = ring_typ[s];
								r.tick = ring_tick[s];
								r.dl = ring_dl[s];
								r.dm = ring_dm[s];
								r.dh = ring_dh[s] & 32'h00FF_FFFF;
								r.slot = s[9:0];
								r.crc = ring_crc[s];
								break;
							end
							want--;
						end
						s = (s + RING - 1) % RING;
					end
				end
			end
			cel_pkg::CMD_RESCAN: begin
				live_count = 0;
				top = '0;
				found = 1'b0;
				s = 0;
				for (int i = 0; i < RING; i++) begin
					if (ring_used[i]) begin
						live_count++;
						if (ring_seq[i] >= top) begin
							top = ring_seq[i];
							s = i;
							found = 1'b1;
						end
					end
				end
				last_seq = found ? top : 32'd0;
				next_slot = found ? (s + 1) % RING : 0;
				r.ok = 1'b1;
				r.seq = last_seq;
			end
			default: ;
		endcase
		r.count = live_count[10:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	function automatic event_cmd_t random_cmd();
		event_cmd_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.cmd = pick < 50 ? cel_pkg::CMD_APPEND : pick < 85 ? cel_pkg::CMD_READ :
			pick < 95 ? cel_pkg::CMD_RESCAN : CMD_UNUSED;
		it.typ = 8'($urandom);
		it.tick = $urandom;
		it.dl = {$urandom, $urandom};
		it.dm = {$urandom, $urandom};
		it.dh = $urandom;
		it.idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 70));
		return it;
	endfunction

	function automatic event_cmd_t make_cmd(input logic [1:0] cmd, input logic [9:0] idx,
			input logic fill);
		event_cmd_t it;
		it.cmd = cmd;
		it.typ = {8{fill}};
		it.tick = {32{fill}};
		it.dl = {64{fill}};
		it.dm = {64{fill}};
		it.dh = {32{fill}};
		it.idx = idx;
		return it;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(1, 16) - 1;
					s_tvalid <= 1'b0;
				end else begin
					event_cmd_t it;
					it = pending_cmds.pop_front();
					s_tuser <= it.cmd;
					s_tdata <= {6'd0, it.idx, it.dh, it.dm, it.dl, it.tick, it.typ};
					s_tvalid <= 1'b1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				event_cmd_t it;
				it.cmd = s_tuser;
				{it.idx, it.dh, it.dm, it.dl, it.tick, it.typ} = s_tdata[209:0];
				expected_results.push_back(log_step(it));
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer, actual %h", $time, m_tdata);
				end else begin
					log_result_t e;
					e = expected_results.pop_front();
					check_field("ok", 64'(e.ok), 64'(m_tdata[0]));
					check_field("seq_out", 64'(e.seq), 64'(m_tdata[32:1]));
					check_field("type_out", 64'(e.typ), 64'(m_tdata[40:33]));
					check_field("tick_out", 64'(e.tick), 64'(m_tdata[72:41]));
					check_field("detail_low_out", e.dl, m_tdata[136:73]);
					check_field("detail_middle_out", e.dm, m_tdata[200:137]);
					check_field("detail_high_out", 64'(e.dh), 64'(m_tdata[232:201]));
					check_field("slot_out", 64'(e.slot), 64'(m_tdata[242:233]));
					check_field("count_out", 64'(e.count), 64'(m_tdata[253:243]));
					check_field("crc_out", 64'(e.crc), 64'(m_tdata[269:254]));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = cel_pkg::CMD_APPEND;
		m_tready = 1'b0;
		in_taken = 1'b0;
		gap_left = 0;
		stall_left = 0;
		calm = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		last_seq = '0;
		next_slot = 0;
		live_count = 0;
		for (int i = 0; i < RING; i++) begin
			ring_used[i] = 1'b0;
		end

		// empty store, unused code, extremes, miss past the end
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'd0, 1'b0));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_RESCAN, 10'd0, 1'b0));
		pending_cmds.push_back(make_cmd(CMD_UNUSED, 10'h3FF, 1'b1));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_APPEND, 10'd0, 1'b0));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_APPEND, 10'h3FF, 1'b1));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'd0, 1'b0));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'd1, 1'b1));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'd2, 1'b0));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'h3FF, 1'b1));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_RESCAN, 10'd0, 1'b1));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_APPEND, 10'd0, 1'b1));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'd0, 1'b0));
		pending_cmds.push_back(make_cmd(CMD_UNUSED, 10'd0, 1'b0));
		// fill past the ring size to wrap and saturate
		for (int i = 0; i < 70; i++) begin
			event_cmd_t it;
			it = random_cmd();
			it.cmd = cel_pkg::CMD_APPEND;
			pending_cmds.push_back(it);
		end
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'd63, 1'b0));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'd64, 1'b0));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_RESCAN, 10'd0, 1'b0));
		pending_cmds.push_back(make_cmd(cel_pkg::CMD_READ, 10'd0, 1'b1));
		for (int i = 0; i < 760; i++) begin
			pending_cmds.push_back(random_cmd());
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() > 100) @(posedge clk);
		calm = 1'b1;
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
